// ===== rtl/core/dmc_pkg.sv =====
// Shared types and constants of the door motor controller.
package dmc_pkg;

    // Fixed field widths
    localparam int unsigned NOW_W     = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Request codes
    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_OPEN  = 2'd1;
    localparam logic [1:0] REQ_CLOSE = 2'd2;

    // Motor relay codes
    localparam logic [1:0] DRIVE_STOP = 2'd0;
    localparam logic [1:0] DRIVE_UP   = 2'd1;
    localparam logic [1:0] DRIVE_DOWN = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VALID_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIME    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME_MAX = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] RST_VALID_COUNT   = 16'd100;
    localparam logic [CFG_W-1:0] RST_CLOSE_TIME    = 16'd30;
    localparam logic [CFG_W-1:0] RST_OPEN_TIME_MAX = 16'd60;

    // One poll item
    typedef struct packed {
        logic [NOW_W-1:0] now;
        logic             end_switch_low;
        logic             up_button_low;
        logic             down_button_low;
        logic [1:0]       request;
    } t_poll;

    // One result item
    typedef struct packed {
        logic [1:0] motor_drive;
        logic       door_is_up;
        logic       target_is_up;
        logic       motion_ended;
        logic       move_started;
        logic       sleep_request;
    } t_result;

    // Current configuration
    typedef struct packed {
        logic [CFG_W-1:0] valid_count;
        logic [CFG_W-1:0] close_time;
        logic [CFG_W-1:0] open_time_max;
    } t_cfg;

endpackage

// ===== rtl/core/dmc_if.sv =====
// Handshake channel interfaces: poll input, result output and configuration write.
interface dmc_poll_if import dmc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [NOW_W-1:0] now;
    logic             end_switch_low;
    logic             up_button_low;
    logic             down_button_low;
    logic [1:0]       request;

    modport source (output valid, now, end_switch_low, up_button_low, down_button_low,
                    request, input ready);
    modport sink   (input valid, now, end_switch_low, up_button_low, down_button_low,
                    request, output ready);
endinterface

interface dmc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] motor_drive;
    logic       door_is_up;
    logic       target_is_up;
    logic       motion_ended;
    logic       move_started;
    logic       sleep_request;

    modport source (output valid, motor_drive, door_is_up, target_is_up, motion_ended,
                    move_started, sleep_request, input ready);
    modport sink   (input valid, motor_drive, door_is_up, target_is_up, motion_ended,
                    move_started, sleep_request, output ready);
endinterface

interface dmc_cfg_if import dmc_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/dmc_step.sv =====
// Controller state and the per-poll update: requests, debounce, stop checks, drive.
module dmc_step import dmc_pkg::*; #(
    parameter int unsigned TIME_BITS  = 32,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_poll   i_poll,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    // Controller state
    logic                  r_door_up,    n_door_up;
    logic                  r_target_up,  n_target_up;
    logic [COUNT_BITS-1:0] r_switch_cnt, n_switch_cnt;
    logic [COUNT_BITS-1:0] r_up_cnt,     n_up_cnt;
    logic [COUNT_BITS-1:0] r_dn_cnt,     n_dn_cnt;
    logic [TIME_BITS-1:0]  r_open_start, n_open_start;
    logic [TIME_BITS-1:0]  r_close_start, n_close_start;
    logic [1:0]            r_drive,      n_drive;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] close_age;
    logic [TIME_BITS-1:0] open_age;
    logic                 up_valid;
    logic                 dn_valid;
    logic                 sw_valid;
    logic                 started;
    logic                 ended;
    logic                 sleep;
    logic                 tgt_req;
    logic                 tgt_up_btn;
    logic                 door_sw;
    logic                 door_close;

    assign now_t = TIME_BITS'(i_poll.now);

    // Saturating debounce counters: cleared when inactive
    assign n_up_cnt = !i_poll.up_button_low ? '0 :
                      (&r_up_cnt) ? r_up_cnt : r_up_cnt + COUNT_BITS'(1);
    assign n_dn_cnt = !i_poll.down_button_low ? '0 :
                      (&r_dn_cnt) ? r_dn_cnt : r_dn_cnt + COUNT_BITS'(1);
    assign n_switch_cnt = !i_poll.end_switch_low ? '0 :
                          (&r_switch_cnt) ? r_switch_cnt : r_switch_cnt + COUNT_BITS'(1);

    assign up_valid = CFG_W'(n_up_cnt) > i_cfg.valid_count;
    assign dn_valid = CFG_W'(n_dn_cnt) > i_cfg.valid_count;
    assign sw_valid = CFG_W'(n_switch_cnt) > i_cfg.valid_count;

    // Target chain: request, up button, down button, both-held freeze
    always_comb begin
        n_open_start  = r_open_start;
        n_close_start = r_close_start;
        started       = 1'b0;

        // external request, close before open
        tgt_req = r_target_up;
        if (i_poll.request == REQ_CLOSE) begin
            if (r_target_up) begin
                n_close_start = now_t;
                started       = 1'b1;
            end
            tgt_req = 1'b0;
        end else if (i_poll.request == REQ_OPEN) begin
            if (!r_target_up) begin
                n_open_start = now_t;
                started      = 1'b1;
            end
            tgt_req = 1'b1;
        end

        // up button
        tgt_up_btn = tgt_req;
        if (up_valid) begin
            if (!tgt_req) begin
                n_open_start = now_t;
                started      = 1'b1;
            end
            tgt_up_btn = 1'b1;
        end

        // down button
        n_target_up = tgt_up_btn;
        if (dn_valid) begin
            if (tgt_up_btn) begin
                n_close_start = now_t;
                started       = 1'b1;
            end
            n_target_up = 1'b0;
        end

        // both held: hold position
        sleep = up_valid && dn_valid;
        if (sleep) begin
            n_target_up = r_door_up;
        end
    end

    assign close_age = now_t - n_close_start;
    assign open_age  = now_t - n_open_start;

    // Stop conditions: end switch, close timer, open timeout
    assign door_sw    = r_door_up || (n_target_up && sw_valid);
    assign door_close = (door_sw && !n_target_up && close_age > TIME_BITS'(i_cfg.close_time))
                        ? 1'b0 : door_sw;
    assign n_door_up  = (!door_close && n_target_up
                         && open_age > TIME_BITS'(i_cfg.open_time_max)) ? 1'b1 : door_close;

    // Motor drive
    always_comb begin
        ended = 1'b0;
        if (n_door_up && !n_target_up) begin
            n_drive = DRIVE_DOWN;
        end else if (!n_door_up && n_target_up) begin
            n_drive = DRIVE_UP;
        end else begin
            ended   = (r_drive != DRIVE_STOP);
            n_drive = DRIVE_STOP;
        end
    end

    // State update, once per poll
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_door_up     <= 1'b0;
            r_target_up   <= 1'b1;
            r_switch_cnt  <= '0;
            r_up_cnt      <= '0;
            r_dn_cnt      <= '0;
            r_open_start  <= '0;
            r_close_start <= '0;
            r_drive       <= DRIVE_STOP;
        end else if (i_fire) begin
            r_door_up     <= n_door_up;
            r_target_up   <= n_target_up;
            r_switch_cnt  <= n_switch_cnt;
            r_up_cnt      <= n_up_cnt;
            r_dn_cnt      <= n_dn_cnt;
            r_open_start  <= n_open_start;
            r_close_start <= n_close_start;
            r_drive       <= n_drive;
        end
    end

    assign o_result.motor_drive   = n_drive;
    assign o_result.door_is_up    = n_door_up;
    assign o_result.target_is_up  = n_target_up;
    assign o_result.motion_ended  = ended;
    assign o_result.move_started  = started;
    assign o_result.sleep_request = sleep;

endmodule

// ===== rtl/core/door_motor_controller.sv =====
// Door motor controller top level: channels, configuration registers, pipeline.
//
//   channel   dir  modport  payload
//   i_poll    in   sink     now, end_switch_low, up_button_low, down_button_low, request
//   o_result  out  source   motor_drive, door_is_up, target_is_up, motion_ended,
//                           move_started, sleep_request
//   i_cfg     in   sink     index, data (valid_count, close_time, open_time_max)
//
// One poll per clock sustained while results are taken; a poll passes from the input
// register through the update logic into the result register.
// The state update of one poll completes in the same cycle it leaves the input register.
// Synchronous active-low reset restores state and configuration defaults.
// A stalled result holds; the input register still takes one more poll behind it.
// Configuration writes are always accepted; index 3 is ignored.
module door_motor_controller import dmc_pkg::*; #(
    parameter int unsigned TIME_BITS  = 32,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmc_poll_if.sink    i_poll,
    dmc_result_if.source o_result,
    dmc_cfg_if.sink     i_cfg
);

    t_cfg    r_cfg;
    logic    r_s1_valid;
    t_poll   r_s1_poll;
    logic    r_out_valid;
    t_result r_out;
    t_result step_result;
    logic    s2_ready;
    logic    s1_ready;
    logic    fire;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.valid_count   <= RST_VALID_COUNT;
            r_cfg.close_time    <= RST_CLOSE_TIME;
            r_cfg.open_time_max <= RST_OPEN_TIME_MAX;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_VALID_COUNT:   r_cfg.valid_count   <= i_cfg.data;
                CFG_CLOSE_TIME:    r_cfg.close_time    <= i_cfg.data;
                CFG_OPEN_TIME_MAX: r_cfg.open_time_max <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Handshake: each stage moves when the one after it has room
    assign s2_ready     = !r_out_valid || o_result.ready;
    assign fire         = r_s1_valid && s2_ready;
    assign s1_ready     = !r_s1_valid || s2_ready;
    assign i_poll.ready = s1_ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_poll.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_poll.valid) begin
            r_s1_poll.now             <= i_poll.now;
            r_s1_poll.end_switch_low  <= i_poll.end_switch_low;
            r_s1_poll.up_button_low   <= i_poll.up_button_low;
            r_s1_poll.down_button_low <= i_poll.down_button_low;
            r_s1_poll.request         <= i_poll.request;
        end
    end

    dmc_step #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_poll   (r_s1_poll),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= step_result;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.motor_drive   = r_out.motor_drive;
    assign o_result.door_is_up    = r_out.door_is_up;
    assign o_result.target_is_up  = r_out.target_is_up;
    assign o_result.motion_ended  = r_out.motion_ended;
    assign o_result.move_started  = r_out.move_started;
    assign o_result.sleep_request = r_out.sleep_request;

    // Drive code agrees with position and target
    a_drive_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.motor_drive == DRIVE_UP |-> !r_out.door_is_up && r_out.target_is_up)
        else $error("drive up without door down and target up");

    // A motion end only comes with released relays
    a_ended_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.motion_ended |-> r_out.motor_drive == DRIVE_STOP)
        else $error("motion ended while relays driven");

    // Both buttons held freezes the target at the position
    a_sleep_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.sleep_request |-> r_out.target_is_up == r_out.door_is_up)
        else $error("sleep request with target off position");

    // A poll waiting in the input register is not overwritten
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_ready |=> r_s1_valid && $stable(r_s1_poll))
        else $error("waiting poll lost or changed");

endmodule
